/* rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, sizes and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W = 5;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic               func;
        logic signed [31:0] item_data;
        logic signed [15:0] item_priority;
    } t_req;

    typedef struct packed {
        logic               removed_valid;
        logic signed [31:0] removed_data;
        logic signed [15:0] removed_priority;
        logic [1:0]         status;
        logic [OCC_W-1:0]   occupancy;
    } t_rsp;

    typedef struct packed {
        logic signed [31:0] data;
        logic signed [15:0] prio;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

/* rtl/spq_ctrl.sv */
// ----------------------------------------------------------------------------
// spq_ctrl
// Request sequencer: captures a request, then runs it once the result
// register is free.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output spq_pkg::t_cmd o_cmd
);

    spq_pkg::t_state r_state;
    spq_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && i_out_stall;
        o_cmd         = '0;
        o_in_stall    = 1'b1;
        unique case (r_state)
            spq_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = spq_pkg::S_EXEC;
                end
            end
            spq_pkg::S_EXEC: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.execute = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = spq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spq_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/spq_datapath.sv */
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted entry row with parallel compare and shift, request register and
// result register.
// ----------------------------------------------------------------------------
module spq_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  spq_pkg::t_cmd i_cmd,
    input  spq_pkg::t_req i_req,
    output spq_pkg::t_rsp o_rsp
);

    spq_pkg::t_req                 r_req;
    spq_pkg::t_rsp                 r_rsp;
    spq_pkg::t_rsp                 n_rsp;
    spq_pkg::t_entry               r_entry [spq_pkg::DEPTH];
    spq_pkg::t_entry               n_entry [spq_pkg::DEPTH];
    logic [spq_pkg::CNT_W-1:0]     r_count;
    logic [spq_pkg::CNT_W-1:0]     n_count;
    logic [spq_pkg::DEPTH-1:0]     gt;
    spq_pkg::t_entry               new_entry;
    logic                          is_full;
    logic                          is_empty;

    assign new_entry.data = r_req.item_data;
    assign new_entry.prio = r_req.item_priority;
    assign is_full  = (r_count == spq_pkg::CNT_W'(spq_pkg::DEPTH));
    assign is_empty = (r_count == '0);

    always_comb begin
        for (int i = 0; i < spq_pkg::DEPTH; i++) begin
            gt[i] = (spq_pkg::CNT_W'(i) < r_count) &&
                    ($signed(r_entry[i].prio) > $signed(r_req.item_priority));
        end
    end

    always_comb begin
        n_count = r_count;
        for (int i = 0; i < spq_pkg::DEPTH; i++) begin
            n_entry[i] = r_entry[i];
        end
        n_rsp = '0;
        if (r_req.func == spq_pkg::FUNC_ENQ) begin
            if (is_full) begin
                n_rsp.status = spq_pkg::STAT_FULL;
            end else begin
                n_rsp.status = spq_pkg::STAT_OK;
                n_count      = r_count + 1'b1;
                if (gt[0] || is_empty) begin
                    n_entry[0] = new_entry;
                end
                for (int i = 1; i < spq_pkg::DEPTH; i++) begin
                    if (gt[i-1]) begin
                        n_entry[i] = r_entry[i-1];
                    end else if (gt[i] || (spq_pkg::CNT_W'(i) == r_count)) begin
                        n_entry[i] = new_entry;
                    end
                end
            end
        end else begin
            if (is_empty) begin
                n_rsp.status = spq_pkg::STAT_EMPTY;
            end else begin
                n_rsp.status           = spq_pkg::STAT_OK;
                n_rsp.removed_valid    = 1'b1;
                n_rsp.removed_data     = r_entry[0].data;
                n_rsp.removed_priority = r_entry[0].prio;
                n_count                = r_count - 1'b1;
                for (int i = 0; i < spq_pkg::DEPTH - 1; i++) begin
                    n_entry[i] = r_entry[i+1];
                end
            end
        end
        n_rsp.occupancy = spq_pkg::OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.execute) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.execute) begin
            r_rsp <= n_rsp;
            for (int i = 0; i < spq_pkg::DEPTH; i++) begin
                r_entry[i] <= n_entry[i];
            end
        end
    end

    assign o_rsp = r_rsp;

endmodule

/* rtl/sorted_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Priority queue kept as a sorted row of entries; enqueue inserts behind
// equal priorities, dequeue removes the head.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake              | Payload
//  in      | input     | i_in_valid / o_in_stall | i_in_req  (spq_pkg::t_req)
//  out     | output    | o_out_valid / i_out_stall | o_out_rsp (spq_pkg::t_rsp)
//
//  A request is first captured; then the execute step compares and shifts
//  the whole entry row at once and loads the result register.
//  The execute cycle waits while the result register holds an untaken result.
//  Reset empties the queue; stored entries themselves are not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  spq_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output spq_pkg::t_rsp o_out_rsp
);

    spq_pkg::t_cmd cmd;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    spq_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_in_req),
        .o_rsp   (o_out_rsp)
    );

endmodule

/* rtl/spq_checker.sv */
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue.
// ----------------------------------------------------------------------------
module spq_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input spq_pkg::t_rsp o_out_rsp
);

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.status == spq_pkg::STAT_EMPTY) |->
        (!o_out_rsp.removed_valid && o_out_rsp.occupancy == '0))
        else $error("empty status with nonzero fields");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.status == spq_pkg::STAT_FULL) |->
        (o_out_rsp.occupancy == spq_pkg::OCC_W'(spq_pkg::DEPTH)))
        else $error("full status with wrong occupancy");

    a_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.removed_valid) |->
        (o_out_rsp.status == spq_pkg::STAT_OK))
        else $error("removed entry without ok status");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while previous one runs");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_rsp)))
        else $error("stalled result changed");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (.*);

/* bench/spq_order_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spq_order_checker
// Watches both channels of the sorted priority queue. It keeps its own
// sorted copy of the stored entries, works out the response to each accepted
// request and compares every accepted response with the oldest one due.
// ----------------------------------------------------------------------------
module spq_order_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  spq_pkg::t_req i_in_req,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  spq_pkg::t_rsp i_out_rsp,
    output int            o_errors,
    output int            o_pending,
    output int            o_checked,
    output int            o_full_seen,
    output int            o_empty_seen
);

    logic signed [31:0] sorted_data[$];
    logic signed [15:0] sorted_prio[$];
    spq_pkg::t_rsp      due_rsp[$];

    int error_count  = 0;
    int check_count  = 0;
    int full_count   = 0;
    int empty_count  = 0;

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("spq_order_checker: %s expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        spq_pkg::t_rsp      want;
        spq_pkg::t_rsp      got;
        logic signed [15:0] new_prio;
        int                 pos;

        if (!i_rst_n) begin
            sorted_data.delete();
            sorted_prio.delete();
            due_rsp.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = i_out_rsp;
                if (due_rsp.size() == 0) begin
                    $error("spq_order_checker: response with none due: %0h", got);
                    error_count++;
                end else begin
                    want = due_rsp.pop_front();
                    compare_field("removed_valid", 32'(want.removed_valid),
                                  32'(got.removed_valid));
                    compare_field("removed_data", want.removed_data, got.removed_data);
                    compare_field("removed_priority", 32'(want.removed_priority),
                                  32'(got.removed_priority));
                    compare_field("status", 32'(want.status), 32'(got.status));
                    compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
                    check_count++;
                end
            end

            if (i_in_valid && !i_in_stall) begin
                want = '0;
                want.status = spq_pkg::STAT_OK;
                if (i_in_req.func == spq_pkg::FUNC_ENQ) begin
                    if (sorted_prio.size() >= spq_pkg::DEPTH) begin
                        want.status = spq_pkg::STAT_FULL;
                        full_count++;
                    end else begin
                        // insert behind every entry of equal or lower priority
                        new_prio = i_in_req.item_priority;
                        pos = sorted_prio.size();
                        while (pos > 0 && sorted_prio[pos - 1] > new_prio)
                            pos--;
                        sorted_prio.insert(pos, new_prio);
                        sorted_data.insert(pos, i_in_req.item_data);
                    end
                end else if (sorted_prio.size() == 0) begin
                    want.status = spq_pkg::STAT_EMPTY;
                    empty_count++;
                end else begin
                    want.removed_valid    = 1'b1;
                    want.removed_data     = sorted_data.pop_front();
                    want.removed_priority = sorted_prio.pop_front();
                end
                want.occupancy = spq_pkg::OCC_W'(sorted_prio.size());
                due_rsp.push_back(want);
            end
        end

        o_errors     <= error_count;
        o_pending    <= due_rsp.size();
        o_checked    <= check_count;
        o_full_seen  <= full_count;
        o_empty_seen <= empty_count;
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the sorted priority queue with a directed run over the corner cases
// (empty dequeue, full enqueue, extreme and equal priorities) and then a long
// random mix of enqueues and dequeues under random sender gaps and receiver
// stalls. The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_COUNT = 700;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    spq_pkg::t_req in_req    = '0;
    logic          out_stall = 1'b0;
    logic          in_stall;
    logic          out_valid;
    spq_pkg::t_rsp out_rsp;

    int errors;
    int pending;
    int checked;
    int full_seen;
    int empty_seen;

    int cycles      = 0;
    int sent        = 0;
    int burst_left  = 0;
    int stall_phase = 0;
    int stall_pct   = 0;

    always #5 clk = ~clk;

    sorted_priority_queue_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_rsp   (out_rsp)
    );

    spq_order_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_rsp    (out_rsp),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_seen  (full_seen),
        .o_empty_seen (empty_seen)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cycles);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (stall_phase == 0) begin
            stall_phase <= $urandom_range(40, 120);
            case ($urandom_range(3))
                0: stall_pct <= 0;
                1: stall_pct <= 20;
                2: stall_pct <= 50;
                default: stall_pct <= 85;
            endcase
        end else begin
            stall_phase <= stall_phase - 1;
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic spq_pkg::t_req make_req(input logic func, input logic [31:0] data,
                                               input logic [15:0] prio);
        spq_pkg::t_req r;
        r.func          = func;
        r.item_data     = data;
        r.item_priority = prio;
        return r;
    endfunction

    function automatic logic [15:0] pick_priority();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return 16'($signed($urandom_range(7)) - 4);
        if (sel < 85)
            return 16'($urandom);
        case ($urandom_range(3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            default: return 16'h0000;
        endcase
    endfunction

    task automatic send_request(input spq_pkg::t_req r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic run_directed();
        logic [31:0] corner_data [0:7];
        logic [15:0] corner_prio [0:7];
        corner_data = '{32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'hFFFFFFFF,
                        32'h00000001, 32'h55555555, 32'hAAAAAAAA, 32'h12345678};
        corner_prio = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0000,
                        16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
        send_request(make_req(spq_pkg::FUNC_DEQ, 32'hFFFFFFFF, 16'hFFFF));
        for (int k = 0; k < 8; k++)
            send_request(make_req(spq_pkg::FUNC_ENQ, corner_data[k], corner_prio[k]));
        for (int k = 8; k < spq_pkg::DEPTH; k++)
            send_request(make_req(spq_pkg::FUNC_ENQ, $urandom, pick_priority()));
        send_request(make_req(spq_pkg::FUNC_ENQ, 32'hDEADBEEF, 16'h8000));
        repeat (5) send_request(make_req(spq_pkg::FUNC_DEQ, $urandom, 16'($urandom)));
    endtask

    initial begin
        int enq_pct;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        enq_pct = 50;
        for (int k = 0; k < RANDOM_COUNT; k++) begin
            // shift the mix so occupancy sweeps from empty to full and back
            if (k % 50 == 0) begin
                case ($urandom_range(4))
                    0: enq_pct = 10;
                    1: enq_pct = 35;
                    2: enq_pct = 50;
                    3: enq_pct = 70;
                    default: enq_pct = 92;
                endcase
            end
            if ($urandom_range(99) < enq_pct)
                send_request(make_req(spq_pkg::FUNC_ENQ, $urandom, pick_priority()));
            else
                send_request(make_req(spq_pkg::FUNC_DEQ, $urandom, 16'($urandom)));
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        $display("tb_top: %0d requests sent, %0d responses checked", sent, checked);
        $display("tb_top: %0d enqueues dropped when full, %0d dequeues on empty",
                 full_seen, empty_seen);
        if (errors == 0 && pending == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
